[rtl/ipt_pkg.sv]
// ipt_pkg: shared request codes for the IPv4 prefix-set trie.
// No dependencies.
`default_nettype none
package ipt_pkg;
  localparam logic REQ_INSERT = 1'b0;
  localparam logic REQ_LOOKUP = 1'b1;
endpackage
`default_nettype wire

[rtl/ipv4_prefix_set_trie_core.sv]
// ipv4_prefix_set_trie_core: IPv4 prefix set held as a binary trie in a node pool; uses ipt_pkg.
// Lookup: walks the trie from the root one level at a time, then hands the result over.
// Insert: walks existing levels, allocates a node for each missing level, frees the subtree below
// an existing node, merges leaf siblings, writes the leaf, then hands the result over.
// One word in flight; a finished result waits in the output register so the next can start.
// Reset: a clearing pass over every node row rebuilds the node rows and free stack first.
`default_nettype none
module ipv4_prefix_set_trie_core #(
  parameter int POOL_NODES = 4096,
  parameter int ADDR_BITS  = 32
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic        req_type_i,
  input  wire logic [31:0] address_i,
  input  wire logic [5:0]  prefix_len_i,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic             hit_or_ok_o,
  output logic             pool_exhausted_o
);
  import ipt_pkg::*;

  localparam int IW = $clog2(POOL_NODES);
  localparam int CW = IW + 1;
  localparam int LW = $clog2(ADDR_BITS + 1);

  typedef logic [IW-1:0] idx_t;

  typedef enum logic [4:0] {
    S_CLR, S_IDLE, S_LK_CHK, S_IN_CHK, S_IN_POP, S_IN_LINK,
    S_DR_P1, S_DR_P2, S_DR_POP, S_DR_WL, S_DR_RD,
    S_MG_RD, S_MG_PAR, S_MG_SIB, S_MG_CHK, S_MG_FREE2, S_MG_LEAF, S_DONE
  } state_e;

  // node memories: read data registered
  idx_t lc_mem [POOL_NODES];
  idx_t rc_mem [POOL_NODES];
  idx_t par_mem [POOL_NODES];
  logic lf_mem [POOL_NODES];
  idx_t fs_mem [POOL_NODES];
  idx_t wl_mem [POOL_NODES];

  state_e     state_q;
  idx_t       cur_q, nxt_q, aux_q, par_q, clr_q;
  logic [CW-1:0] fc_q, sp_q;
  logic [31:0] addr_q;
  logic [LW-1:0] len_q, lvl_q;
  logic       made_q, hit_q, exh_q, ov_q, res_hit_q, res_exh_q;
  idx_t       lc_r, rc_r, par_r, fs_r, wl_r;
  logic       lf_r;
  // read addresses, taken this cycle, data next cycle
  idx_t       rd_a;   // node rows
  idx_t       rd_fa;  // free stack, always the top entry
  idx_t       rd_wa;  // worklist, always the top entry
  logic       bit_w;

  always_comb begin
    bit_w = addr_q[5'(ADDR_BITS - 1) - 5'(lvl_q)];
  end

  // registered reads
  always_ff @(posedge clk_i) begin
    lc_r  <= lc_mem[rd_a];
    rc_r  <= rc_mem[rd_a];
    par_r <= par_mem[rd_a];
    lf_r  <= lf_mem[rd_a];
    fs_r  <= fs_mem[rd_fa];
    wl_r  <= wl_mem[rd_wa];
  end

  // node write port: one row a cycle
  logic       nw_lc_en, nw_rc_en, nw_lf_en, nw_par_en;
  idx_t       nw_a, nw_lc, nw_rc, nw_par;
  logic       nw_lf;
  logic       fw_en, ww_en;
  idx_t       fw_a, fw_d, ww_a, ww_d;

  always_ff @(posedge clk_i) begin
    if (nw_lc_en) lc_mem[nw_a] <= nw_lc;
    if (nw_rc_en) rc_mem[nw_a] <= nw_rc;
    if (nw_lf_en) lf_mem[nw_a] <= nw_lf;
    if (nw_par_en) par_mem[nw_a] <= nw_par;
    if (fw_en) fs_mem[fw_a] <= fw_d;
    if (ww_en) wl_mem[ww_a] <= ww_d;
  end

  state_e s_d;
  idx_t   cur_d, nxt_d, aux_d, par_d, clr_d;
  logic [CW-1:0] fc_d, sp_d;
  logic [LW-1:0] lvl_d, len_d;
  logic [31:0]   addr_d;
  logic   made_d, hit_d, exh_d, ov_d, res_hit_d, res_exh_d;
  idx_t   child_w, sib_w;

  always_comb begin
    s_d = state_q; cur_d = cur_q; nxt_d = nxt_q; aux_d = aux_q; par_d = par_q;
    clr_d = clr_q; fc_d = fc_q; sp_d = sp_q; lvl_d = lvl_q; len_d = len_q;
    addr_d = addr_q; made_d = made_q; hit_d = hit_q; exh_d = exh_q; ov_d = ov_q;
    res_hit_d = res_hit_q; res_exh_d = res_exh_q;
    rd_a = cur_q; rd_fa = idx_t'(fc_q - CW'(1)); rd_wa = idx_t'(sp_q - CW'(1));
    nw_lc_en = 1'b0; nw_rc_en = 1'b0; nw_lf_en = 1'b0; nw_par_en = 1'b0;
    nw_a = cur_q; nw_lc = '0; nw_rc = '0; nw_lf = 1'b0; nw_par = cur_q;
    fw_en = 1'b0; fw_a = idx_t'(fc_q); fw_d = '0;
    ww_en = 1'b0; ww_a = idx_t'(sp_q); ww_d = '0;
    child_w = bit_w ? rc_r : lc_r;
    sib_w = (lc_r == nxt_q) ? rc_r : lc_r;
    if (ov_q && out_ready) ov_d = 1'b0;
    unique case (state_q)
      // clearing pass: empty rows, free stack holds 1..POOL_NODES-1
      S_CLR: begin
        nw_lc_en = 1'b1; nw_rc_en = 1'b1; nw_lf_en = 1'b1;
        nw_a = clr_q;
        fw_en = (clr_q != idx_t'(POOL_NODES-1));
        fw_a = clr_q; fw_d = clr_q + idx_t'(1);
        clr_d = clr_q + idx_t'(1);
        if (clr_q == idx_t'(POOL_NODES-1)) s_d = S_IDLE;
      end
      S_IDLE: begin
        if (in_valid) begin
          cur_d = '0; rd_a = '0; lvl_d = '0; made_d = 1'b0;
          hit_d = 1'b0; exh_d = 1'b0;
          addr_d = address_i;
          len_d = (prefix_len_i > 6'(ADDR_BITS)) ? LW'(ADDR_BITS) : LW'(prefix_len_i);
          s_d = (req_type_i == REQ_LOOKUP) ? S_LK_CHK : S_IN_CHK;
        end
      end
      // lookup: row of cur is in the read registers, next row fetched in the same cycle
      S_LK_CHK: begin
        if (lf_r) begin
          hit_d = 1'b1; s_d = S_DONE;
        end else if (lvl_q == len_q || child_w == '0) begin
          s_d = S_DONE;
        end else begin
          cur_d = child_w; rd_a = child_w; lvl_d = lvl_q + LW'(1);
        end
      end
      // insert walk: a leaf on the path (root included) already covers the prefix
      S_IN_CHK: begin
        if (lf_r) begin
          hit_d = 1'b1; s_d = S_DONE;
        end else if (lvl_q == len_q) begin
          if (made_q) begin
            nxt_d = cur_q; s_d = S_MG_RD;
          end else begin
            // existing node: free everything below it first
            nxt_d = lc_r; aux_d = rc_r; sp_d = '0; s_d = S_DR_P1;
          end
        end else if (child_w != '0) begin
          cur_d = child_w; rd_a = child_w; lvl_d = lvl_q + LW'(1);
        end else if (fc_q == '0) begin
          exh_d = 1'b1; s_d = S_DONE;
        end else begin
          s_d = S_IN_POP;
        end
      end
      // top of free stack is in fs_r: clear its row and link it to cur
      S_IN_POP: begin
        fc_d = fc_q - CW'(1); aux_d = fs_r;
        nw_lc_en = 1'b1; nw_rc_en = 1'b1; nw_lf_en = 1'b1; nw_par_en = 1'b1;
        nw_a = fs_r; nw_par = cur_q;
        s_d = S_IN_LINK;
      end
      S_IN_LINK: begin
        nw_a = cur_q; nw_lc = aux_q; nw_rc = aux_q;
        if (bit_w) nw_rc_en = 1'b1;
        else nw_lc_en = 1'b1;
        made_d = 1'b1; cur_d = aux_q; rd_a = aux_q; lvl_d = lvl_q + LW'(1);
        s_d = S_IN_CHK;
      end
      // subtree prune: nxt/aux hold the pending children, worklist is a stack
      S_DR_P1: begin
        if (nxt_q != '0) begin
          ww_en = 1'b1; ww_d = nxt_q; sp_d = sp_q + CW'(1);
        end
        s_d = S_DR_P2;
      end
      S_DR_P2: begin
        if (aux_q != '0) begin
          ww_en = 1'b1; ww_d = aux_q; sp_d = sp_q + CW'(1);
        end
        s_d = S_DR_POP;
      end
      S_DR_POP: begin
        if (sp_q == '0) begin
          nw_lc_en = 1'b1; nw_rc_en = 1'b1; nw_a = cur_q;
          nxt_d = cur_q; s_d = S_MG_RD;
        end else begin
          sp_d = sp_q - CW'(1); s_d = S_DR_WL;
        end
      end
      S_DR_WL: begin
        par_d = wl_r; rd_a = wl_r; s_d = S_DR_RD;
      end
      S_DR_RD: begin
        nxt_d = lc_r; aux_d = rc_r;
        nw_lc_en = 1'b1; nw_rc_en = 1'b1; nw_lf_en = 1'b1; nw_a = par_q;
        fw_en = 1'b1; fw_d = par_q; fc_d = fc_q + CW'(1);
        s_d = S_DR_P1;
      end
      // merge: nxt is the node to become a leaf, par_q its parent
      S_MG_RD: begin
        if (nxt_q == '0) s_d = S_MG_LEAF;
        else begin
          rd_a = nxt_q; s_d = S_MG_PAR;
        end
      end
      S_MG_PAR: begin
        par_d = par_r; rd_a = par_r; s_d = S_MG_SIB;
      end
      S_MG_SIB: begin
        aux_d = sib_w;
        if (sib_w == '0) s_d = S_MG_LEAF;
        else begin
          rd_a = sib_w; s_d = S_MG_CHK;
        end
      end
      S_MG_CHK: begin
        if (lf_r) begin
          nw_lc_en = 1'b1; nw_rc_en = 1'b1; nw_lf_en = 1'b1; nw_a = aux_q;
          fw_en = 1'b1; fw_d = aux_q; fc_d = fc_q + CW'(1);
          s_d = S_MG_FREE2;
        end else begin
          s_d = S_MG_LEAF;
        end
      end
      S_MG_FREE2: begin
        nw_lc_en = 1'b1; nw_rc_en = 1'b1; nw_lf_en = 1'b1; nw_a = nxt_q;
        fw_en = 1'b1; fw_d = nxt_q; fc_d = fc_q + CW'(1);
        nxt_d = par_q; s_d = S_MG_RD;
      end
      S_MG_LEAF: begin
        nw_lc_en = 1'b1; nw_rc_en = 1'b1; nw_lf_en = 1'b1; nw_a = nxt_q; nw_lf = 1'b1;
        hit_d = 1'b1; s_d = S_DONE;
      end
      // hand over once the output register is free
      S_DONE: begin
        if (!ov_q || out_ready) begin
          ov_d = 1'b1; res_hit_d = hit_q; res_exh_d = exh_q; s_d = S_IDLE;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLR; clr_q <= '0; fc_q <= CW'(POOL_NODES - 1); sp_q <= '0;
      ov_q <= 1'b0; res_hit_q <= 1'b0; res_exh_q <= 1'b0;
      made_q <= 1'b0; hit_q <= 1'b0; exh_q <= 1'b0; lvl_q <= '0; len_q <= '0;
      addr_q <= '0; cur_q <= '0; nxt_q <= '0; aux_q <= '0; par_q <= '0;
    end else begin
      state_q <= s_d; clr_q <= clr_d; fc_q <= fc_d; sp_q <= sp_d;
      ov_q <= ov_d; res_hit_q <= res_hit_d; res_exh_q <= res_exh_d;
      made_q <= made_d; hit_q <= hit_d; exh_q <= exh_d; lvl_q <= lvl_d; len_q <= len_d;
      addr_q <= addr_d; cur_q <= cur_d; nxt_q <= nxt_d; aux_q <= aux_d; par_q <= par_d;
    end
  end

  assign in_ready         = (state_q == S_IDLE);
  assign out_valid        = ov_q;
  assign hit_or_ok_o      = res_hit_q;
  assign pool_exhausted_o = res_exh_q;

  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid && in_ready) |=> !in_ready) else $error("ready during walk");
  a_fc: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fc_q <= CW'(POOL_NODES - 1)) else $error("free count overflow");
  a_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid |-> !(hit_or_ok_o && pool_exhausted_o)) else $error("bad result");
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid && !out_ready) |=>
      (out_valid && $stable(hit_or_ok_o) && $stable(pool_exhausted_o)))
    else $error("result word dropped while waiting");
endmodule
`default_nettype wire
